/* design/pidpc_pkg.sv */
// shared types, constants and register codes for the three-ram position controller
`timescale 1ns / 1ps
`default_nettype none

package pidpc_pkg;

  localparam int NUM_RAMS  = 3;
  localparam int RAM_IDX_W = (NUM_RAMS > 1) ? $clog2(NUM_RAMS) : 1;
  localparam int DRIVE_MAX = 255;

  localparam int POS_FULL = 25600;
  localparam int RAW_FULL = 32767;

  localparam int RAW_W   = 16;
  localparam int SP_W    = 15;
  localparam int GAIN_W  = 16;
  localparam int POS_W   = 16;
  localparam int DRIVE_W = 8;
  localparam int ERR_W   = 18;
  localparam int INTEG_W = 16;
  localparam int PROD_W  = ERR_W + GAIN_W + 1;
  localparam int ACC_W   = PROD_W + 1;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 3;

  localparam logic [REG_W-1:0] REG_SP_CENTER  = REG_W'(0);
  localparam logic [REG_W-1:0] REG_SP_LEFT    = REG_W'(1);
  localparam logic [REG_W-1:0] REG_SP_RIGHT   = REG_W'(2);
  localparam logic [REG_W-1:0] REG_GAIN_PROP  = REG_W'(NUM_RAMS);
  localparam logic [REG_W-1:0] REG_GAIN_INTEG = REG_W'(NUM_RAMS + 1);
  localparam logic [REG_W-1:0] REG_GAIN_DERIV = REG_W'(NUM_RAMS + 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_POS,
    ST_ERR,
    ST_INT,
    ST_MP,
    ST_MI,
    ST_MD,
    ST_SUM,
    ST_DRV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic   load;
    state_t state;
  } lane_ctl_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } gains_t;

  typedef logic [NUM_RAMS-1:0][SP_W-1:0] sp_arr_t;

endpackage

`default_nettype wire

/* design/pidpc_regs.sv */
// configuration register file with setpoint clamping and read back
`timescale 1ns / 1ps
`default_nettype none

module pidpc_regs
  import pidpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output sp_arr_t                sp,
  output gains_t                 gains
);

  logic [REG_W-1:0] idx;
  logic             wr;
  logic [SP_W-1:0]  sp_wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign sp_wr  = (pwdata[SP_W-1:0] > SP_W'(POS_FULL)) ? SP_W'(POS_FULL) : pwdata[SP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sp    <= '0;
      gains <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SP_CENTER, REG_SP_LEFT, REG_SP_RIGHT: sp[idx[RAM_IDX_W-1:0]] <= sp_wr;
        REG_GAIN_PROP:  gains.prop  <= pwdata[GAIN_W-1:0];
        REG_GAIN_INTEG: gains.integ <= pwdata[GAIN_W-1:0];
        REG_GAIN_DERIV: gains.deriv <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SP_CENTER, REG_SP_LEFT, REG_SP_RIGHT:
        prdata = DATA_W'(sp[idx[RAM_IDX_W-1:0]]);
      REG_GAIN_PROP:  prdata = DATA_W'(gains.prop);
      REG_GAIN_INTEG: prdata = DATA_W'(gains.integ);
      REG_GAIN_DERIV: prdata = DATA_W'(gains.deriv);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/pidpc_lane.sv */
// one ram: position scaling, error, clamped integral, derivative and pid drive
`timescale 1ns / 1ps
`default_nettype none

module pidpc_lane
  import pidpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lane_ctl_t               ctl,
  input  wire gains_t                  gains,
  input  wire logic        [SP_W-1:0]  setpoint,
  input  wire logic signed [RAW_W-1:0] raw_in,
  output logic signed      [POS_W-1:0] pos,
  output logic             [DRIVE_W-1:0] drive
);

  localparam int N_W = 30;
  localparam int Q_W = 15;
  localparam int HI_W = ACC_W - 16;
  localparam logic [N_W-1:0] POS_SCALE = N_W'(POS_FULL);
  localparam logic [Q_W:0]   RAW_DIV   = (Q_W + 1)'(RAW_FULL);

  logic signed [RAW_W-1:0]   raw;
  logic        [RAW_W-1:0]   mag;
  logic        [N_W-1:0]     n;
  logic                      neg;
  logic        [Q_W:0]       qsum;
  logic        [Q_W-1:0]     q;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [ERR_W-1:0]   deriv;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W:0]     integ_raw;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [ERR_W:0]     deriv_raw;
  logic signed [ERR_W-1:0]   mul_a;
  logic signed [GAIN_W:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic        [HI_W-1:0]    acc_hi;
  logic        [DRIVE_W-1:0] drive_sat;

  // n / 32767 as hi + (hi + lo) / 32767, the second term is 0 or 1
  assign mag  = raw[RAW_W-1] ? RAW_W'(-raw) : raw;
  assign qsum = {1'b0, n[N_W-1:Q_W]} + {1'b0, n[Q_W-1:0]};
  assign q    = n[N_W-1:Q_W] + Q_W'(qsum >= RAW_DIV);

  assign integ_raw = (ERR_W + 1)'(integral_sum) + (ERR_W + 1)'(err);
  assign integ_sat = (integ_raw > (ERR_W + 1)'(POS_FULL))  ? INTEG_W'(POS_FULL) :
                     (integ_raw < -(ERR_W + 1)'(POS_FULL)) ? -INTEG_W'(POS_FULL) :
                     INTEG_W'(integ_raw);
  assign deriv_raw = (ERR_W + 1)'(err) - (ERR_W + 1)'(last_error);

  assign acc_hi    = acc[ACC_W-1:16];
  assign drive_sat = acc[ACC_W-1] ? '0 :
                     (acc_hi > HI_W'(DRIVE_MAX)) ? DRIVE_W'(DRIVE_MAX) : DRIVE_W'(acc_hi);

  always_comb begin
    case (ctl.state)
      ST_MP: begin
        mul_a = err;
        mul_b = signed'({1'b0, gains.prop});
      end
      ST_MI: begin
        mul_a = ERR_W'(integral_sum);
        mul_b = signed'({1'b0, gains.integ});
      end
      default: begin
        mul_a = deriv;
        mul_b = signed'({1'b0, gains.deriv});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
    end else if (ctl.state == ST_INT) begin
      integral_sum <= integ_sat;
      last_error   <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      raw <= raw_in;
    end
    case (ctl.state)
      ST_MAG: begin
        n   <= N_W'(mag) * POS_SCALE;
        neg <= raw[RAW_W-1];
      end
      ST_POS: pos <= neg ? -POS_W'(q) : POS_W'(q);
      ST_ERR: err <= ERR_W'(setpoint) - ERR_W'(pos);
      ST_INT: deriv <= ERR_W'(deriv_raw);
      ST_MP:  prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      ST_MI: begin
        acc  <= ACC_W'(prod);
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      ST_MD: begin
        acc  <= acc + ACC_W'(prod);
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      ST_SUM: acc <= acc + ACC_W'(prod);
      ST_DRV: drive <= drive_sat;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/three_channel_pid_position_control.sv */
// top level: config port, sequencer, per-ram lanes and merged output register
//
//  port group        | dir | beat / access
//  in_valid/in_stall | in  | raw_center, raw_left, raw_right
//  out_valid/out_stall | out | drive_*, pos_*
//  psel..prdata      | cfg | apb-style, setpoints and gains
//
// a beat steps through mag, pos, err, int, mp, mi, md, sum, drv and done before it is
// loaded into the output register, and the next enters only once the sequencer is back
// in idle; the three lanes run in lockstep, each with one multiplier step per gain term
// a finished beat waits in the output register while a new one is taken
// if the output register is still full and stalled when a lane finishes, the lanes hold
// rst is synchronous and clears config, integrators, previous errors and control
`timescale 1ns / 1ps
`default_nettype none

module three_channel_pid_position_control
  import pidpc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [RAW_W-1:0]   raw_center,
  input  wire logic signed [RAW_W-1:0]   raw_left,
  input  wire logic signed [RAW_W-1:0]   raw_right,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic             [DRIVE_W-1:0] drive_center,
  output logic             [DRIVE_W-1:0] drive_left,
  output logic             [DRIVE_W-1:0] drive_right,
  output logic signed      [POS_W-1:0]   pos_center,
  output logic signed      [POS_W-1:0]   pos_left,
  output logic signed      [POS_W-1:0]   pos_right,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic        [ADDR_W-1:0]  paddr,
  input  wire logic        [DATA_W-1:0]  pwdata,
  output logic             [DATA_W-1:0]  prdata,
  output logic                           pready
);

  state_t    state;
  state_t    state_next;
  lane_ctl_t ctl;
  logic      out_free;
  logic      out_load;
  sp_arr_t   sp;
  gains_t    gains;

  logic [NUM_RAMS-1:0][RAW_W-1:0]   raw_all;
  logic [NUM_RAMS-1:0][POS_W-1:0]   lane_pos;
  logic [NUM_RAMS-1:0][DRIVE_W-1:0] lane_drive;

  pidpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sp      (sp),
    .gains   (gains)
  );

  assign raw_all = {raw_right, raw_left, raw_center};

  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == ST_DONE) && out_free;
  assign ctl.load  = in_valid && !in_stall;
  assign ctl.state = state;

  for (genvar i = 0; i < NUM_RAMS; i++) begin : g_lane
    pidpc_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .gains    (gains),
      .setpoint (sp[i]),
      .raw_in   (raw_all[i]),
      .pos      (lane_pos[i]),
      .drive    (lane_drive[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MAG;
      ST_MAG:  state_next = ST_POS;
      ST_POS:  state_next = ST_ERR;
      ST_ERR:  state_next = ST_INT;
      ST_INT:  state_next = ST_MP;
      ST_MP:   state_next = ST_MI;
      ST_MI:   state_next = ST_MD;
      ST_MD:   state_next = ST_SUM;
      ST_SUM:  state_next = ST_DRV;
      ST_DRV:  state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_center <= lane_drive[0];
      drive_left   <= lane_drive[1];
      drive_right  <= lane_drive[2];
      pos_center   <= lane_pos[0];
      pos_left     <= lane_pos[1];
      pos_right    <= lane_pos[2];
    end
  end

endmodule

`default_nettype wire

/* tb/tb_three_channel_pid_position_control.sv */
// testbench for the three-ram pid position controller: directed table, random phases, predictor
`timescale 1ns / 1ps

module tb_three_channel_pid_position_control;
  import pidpc_pkg::*;

  localparam int LAT_CYC     = 32;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 150;

  localparam logic [REG_W-1:0] REG_NONE_A = REG_W'(6);
  localparam logic [REG_W-1:0] REG_NONE_B = REG_W'(7);

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic [NUM_RAMS-1:0][DRIVE_W-1:0] drive;
    logic [NUM_RAMS-1:0][POS_W-1:0]   pos;
  } ctrl_beat_t;

  typedef struct packed {
    row_kind_e                      kind;
    logic [REG_W-1:0]               reg_idx;
    logic [DATA_W-1:0]              value;
    logic [NUM_RAMS-1:0][RAW_W-1:0] raw;
    logic                           typed;
    ctrl_beat_t                     beat;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [RAW_W-1:0]    raw_center;
  logic [RAW_W-1:0]    raw_left;
  logic [RAW_W-1:0]    raw_right;
  logic                out_valid;
  logic                out_stall;
  logic [DRIVE_W-1:0]  drive_center;
  logic [DRIVE_W-1:0]  drive_left;
  logic [DRIVE_W-1:0]  drive_right;
  logic [POS_W-1:0]    pos_center;
  logic [POS_W-1:0]    pos_left;
  logic [POS_W-1:0]    pos_right;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [SP_W-1:0]     sp_reg [NUM_RAMS];
  logic [GAIN_W-1:0]   gain_p;
  logic [GAIN_W-1:0]   gain_i;
  logic [GAIN_W-1:0]   gain_d;
  longint              integ_acc [NUM_RAMS];
  longint              prev_err [NUM_RAMS];

  ctrl_beat_t          pending_beats [$];
  stim_row_t           plan [$];
  int                  err_count;
  int                  quiet_cycles;
  bit                  calm_tx;
  bit                  calm_rx;

  three_channel_pid_position_control u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_center   (raw_center),
    .raw_left     (raw_left),
    .raw_right    (raw_right),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_center (drive_center),
    .drive_left   (drive_left),
    .drive_right  (drive_right),
    .pos_center   (pos_center),
    .pos_left     (pos_left),
    .pos_right    (pos_right),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= 30)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic ctrl_beat_t pid_predict(input logic [NUM_RAMS-1:0][RAW_W-1:0] raw);
    ctrl_beat_t b;
    longint     pos;
    longint     err;
    longint     acc;
    longint     slope;
    longint     total;
    longint     drv;
    int         i;
    for (i = 0; i < NUM_RAMS; i++) begin
      pos = (longint'($signed(raw[i])) * POS_FULL) / RAW_FULL;
      err = longint'(sp_reg[i]) - pos;
      acc = integ_acc[i] + err;
      if (acc > POS_FULL) acc = POS_FULL;
      if (acc < -POS_FULL) acc = -POS_FULL;
      slope = err - prev_err[i];
      total = longint'(gain_p) * err + longint'(gain_i) * acc + longint'(gain_d) * slope;
      integ_acc[i] = acc;
      prev_err[i]  = err;
      if (total < 0) drv = 0;
      else drv = total >>> 16;
      if (drv > DRIVE_MAX) drv = DRIVE_MAX;
      b.drive[i] = drv[DRIVE_W-1:0];
      b.pos[i]   = pos[POS_W-1:0];
    end
    return b;
  endfunction

  function automatic void shadow_write(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_SP_CENTER, REG_SP_LEFT, REG_SP_RIGHT: begin
        sp_reg[idx] = (value[SP_W-1:0] > POS_FULL) ? SP_W'(POS_FULL) : value[SP_W-1:0];
      end
      REG_GAIN_PROP:  gain_p = value[GAIN_W-1:0];
      REG_GAIN_INTEG: gain_i = value[GAIN_W-1:0];
      REG_GAIN_DERIV: gain_d = value[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] shadow_read(input logic [REG_W-1:0] idx);
    case (idx)
      REG_SP_CENTER, REG_SP_LEFT, REG_SP_RIGHT: return DATA_W'(sp_reg[idx]);
      REG_GAIN_PROP:  return DATA_W'(gain_p);
      REG_GAIN_INTEG: return DATA_W'(gain_i);
      REG_GAIN_DERIV: return DATA_W'(gain_d);
      default: return '0;
    endcase
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw(input int sp);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 35) return RAW_W'($urandom);
    if (r < 45) begin
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h8001;
        2: return 16'hFFFF;
        3: return 16'h0000;
        default: return 16'h7FFF;
      endcase
    end
    v = sp * RAW_FULL / POS_FULL + int'($urandom_range(0, 1200)) - 600;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[RAW_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] pick_setpoint(input int ph);
    int r;
    r = $urandom_range(0, 99);
    if (ph == 0) return POS_FULL;
    if (ph == 1 || r < 15) return 0;
    if (r < 30) return POS_FULL;
    if (r < 38) return $urandom_range(POS_FULL + 1, 32767);
    if (r < 45) return $urandom;
    return $urandom_range(0, POS_FULL);
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain(input int ph);
    int r;
    r = $urandom_range(0, 99);
    if (ph == 0) return 32'h0000_FFFF;
    if (ph == 1 || r < 10) return 0;
    if (r < 20) return 32'h0000_FFFF;
    if (r < 55) return $urandom_range(0, 1500);
    if (r < 80) return $urandom_range(0, 8000);
    return $urandom;
  endfunction

  task automatic apb_access(input logic [REG_W-1:0] idx, input bit wr,
                            input logic [DATA_W-1:0] value, output logic [DATA_W-1:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    apb_access(idx, 1'b1, value, rd);
    shadow_write(idx, value);
    if (idx <= REG_GAIN_DERIV) begin
      apb_access(idx, 1'b0, '0, rd);
      if (rd !== shadow_read(idx))
        report_mismatch($sformatf("readback reg %0d", idx), rd, shadow_read(idx));
    end
  endtask

  task automatic send_samples(input logic [NUM_RAMS-1:0][RAW_W-1:0] raw, input bit typed,
                              input ctrl_beat_t typed_beat);
    int         gap;
    ctrl_beat_t pred;
    gap = pick_gap(calm_tx);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    raw_center <= raw[0];
    raw_left   <= raw[1];
    raw_right  <= raw[2];
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = pid_predict(raw);
    pending_beats.push_back(typed ? typed_beat : pred);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (LAT_CYC) @(posedge clk);
  endtask

  function automatic stim_row_t item_row(input int c, input int l, input int r, input bit typed,
                                         input int pc, input int pl, input int pr);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.raw = {RAW_W'(r), RAW_W'(l), RAW_W'(c)};
    row.typed = typed;
    row.beat.pos = {POS_W'(pr), POS_W'(pl), POS_W'(pc)};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.value = value;
    return row;
  endfunction

  initial begin : out_stall_gen
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (!calm_rx) hold = pick_gap(1'b0);
      end
    end
  end

  always @(posedge clk) begin : out_check
    ctrl_beat_t want;
    ctrl_beat_t got;
    int         i;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      got.drive = {drive_right, drive_left, drive_center};
      got.pos   = {pos_right, pos_left, pos_center};
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing pending", 0, 0);
      end else begin
        want = pending_beats.pop_front();
        for (i = 0; i < NUM_RAMS; i++) begin
          if (got.drive[i] !== want.drive[i])
            report_mismatch($sformatf("drive ram %0d", i), got.drive[i], want.drive[i]);
          if (got.pos[i] !== want.pos[i])
            report_mismatch($sformatf("pos ram %0d", i), $signed(got.pos[i]),
                            $signed(want.pos[i]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : main_seq
    int ph;
    int k;
    stim_row_t row;
    err_count    = 0;
    quiet_cycles = 0;
    calm_tx      = 1'b0;
    calm_rx      = 1'b0;
    gain_p       = '0;
    gain_i       = '0;
    gain_d       = '0;
    for (k = 0; k < NUM_RAMS; k++) begin
      sp_reg[k]    = '0;
      integ_acc[k] = 0;
      prev_err[k]  = 0;
    end
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    raw_center <= '0;
    raw_left   <= '0;
    raw_right  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // zero gains after reset: drive stays at 0
    plan.push_back(item_row(0, 0, 0, 1'b1, 0, 0, 0));
    plan.push_back(item_row(32767, -32768, -32767, 1'b1, 25600, -25600, -25600));
    plan.push_back(item_row(1, -1, 16384, 1'b1, 0, 0, 12800));
    plan.push_back(item_row(-16384, 32766, -2, 1'b1, -12800, 25599, -1));
    plan.push_back(cfg_row(REG_SP_CENTER, 32'd25600));
    plan.push_back(cfg_row(REG_SP_LEFT, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_SP_RIGHT, 32'd25601));
    plan.push_back(cfg_row(REG_GAIN_PROP, 32'd256));
    plan.push_back(cfg_row(REG_GAIN_INTEG, 32'd0));
    plan.push_back(cfg_row(REG_GAIN_DERIV, 32'd0));
    plan.push_back(item_row(0, 0, 0, 1'b0, 0, 0, 0));
    plan.push_back(item_row(32767, 32767, 32767, 1'b0, 0, 0, 0));
    plan.push_back(item_row(32767, -32768, 21000, 1'b0, 0, 0, 0));
    plan.push_back(cfg_row(REG_SP_RIGHT, 32'd0));
    plan.push_back(item_row(16384, 16384, 16384, 1'b0, 0, 0, 0));
    plan.push_back(cfg_row(REG_GAIN_PROP, 32'h0000_FFFF));
    plan.push_back(cfg_row(REG_GAIN_INTEG, 32'h0000_FFFF));
    plan.push_back(cfg_row(REG_GAIN_DERIV, 32'h0000_FFFF));
    plan.push_back(item_row(-32768, -32768, -32768, 1'b0, 0, 0, 0));
    plan.push_back(item_row(32767, 32767, 32767, 1'b0, 0, 0, 0));
    plan.push_back(item_row(0, 0, 0, 1'b0, 0, 0, 0));
    plan.push_back(cfg_row(REG_GAIN_PROP, 32'd3));
    plan.push_back(cfg_row(REG_GAIN_INTEG, 32'd1));
    plan.push_back(cfg_row(REG_GAIN_DERIV, 32'd2));
    plan.push_back(item_row(32766, 32766, 1, 1'b0, 0, 0, 0));
    plan.push_back(item_row(32767, 32767, 0, 1'b0, 0, 0, 0));
    plan.push_back(cfg_row(REG_NONE_A, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_NONE_B, 32'h1234_5678));
    plan.push_back(item_row(-1, 1, 0, 1'b0, 0, 0, 0));
    plan.push_back(cfg_row(REG_SP_CENTER, 32'd12800));
    plan.push_back(cfg_row(REG_SP_LEFT, 32'd0));
    plan.push_back(item_row(16384, 100, -100, 1'b0, 0, 0, 0));
    plan.push_back(item_row(16390, -300, 300, 1'b0, 0, 0, 0));

    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_CFG) begin
        settle();
        set_reg(row.reg_idx, row.value);
      end else begin
        send_samples(row.raw, row.typed, row.beat);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      calm_tx = 1'b0;
      calm_rx = 1'b0;
      set_reg(REG_SP_CENTER, pick_setpoint(ph));
      set_reg(REG_SP_LEFT, pick_setpoint(ph));
      set_reg(REG_SP_RIGHT, pick_setpoint(ph));
      set_reg(REG_GAIN_PROP, pick_gain(ph));
      set_reg(REG_GAIN_INTEG, pick_gain(ph));
      set_reg(REG_GAIN_DERIV, pick_gain(ph));
      if ($urandom_range(0, 2) == 0)
        set_reg($urandom_range(0, 1) ? REG_NONE_A : REG_NONE_B, $urandom);
      calm_tx = (ph % 4 == 3);
      calm_rx = (ph % 5 == 2);
      for (k = 0; k < PHASE_ITEMS; k++)
        send_samples({pick_raw(sp_reg[2]), pick_raw(sp_reg[1]), pick_raw(sp_reg[0])},
                     1'b0, '0);
    end

    settle();
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/pidpc_pkg.sv
design/pidpc_regs.sv
design/pidpc_lane.sv
design/three_channel_pid_position_control.sv
tb/tb_three_channel_pid_position_control.sv
